// File: rtl/core/e2d_pkg.sv
// ----------------------------------------------------------------------------
// e2d_pkg: shared types and constants
// Stage payload structs and format constants for the extended-to-double
// conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package e2d_pkg;

	localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
	localparam int          EXT_BIAS    = 16383;
	localparam int          DBL_BIAS    = 1023;
	localparam logic [10:0] DBL_EXP_INF = 11'h7FF;

	// Result kinds, set in the first stage and updated in the second.
	typedef enum logic [1:0] {
		KIND_NUM,
		KIND_ZERO,
		KIND_INF
	} kind_t;

	// After normalization.
	typedef struct packed {
		logic        sign;
		kind_t       kind;
		logic [63:0] mant;
		logic [17:0] be;      // signed biased double exponent
	} norm_t;

	// After alignment.
	typedef struct packed {
		logic        sign;
		kind_t       kind;
		logic [63:0] base;
		logic [63:0] q;
		logic        rnd_up;
	} align_t;

endpackage
`default_nettype wire

// File: rtl/core/e2d_word_if.sv
// ----------------------------------------------------------------------------
// e2d_word_if: valid/ready channel
// Carries one payload word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface e2d_word_if #(parameter int W = 64);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/extended80_to_double.sv
// ----------------------------------------------------------------------------
// extended80_to_double: 80-bit extended to binary64 converter
// Three-stage pipeline turning an extended-precision value into a double.
// ----------------------------------------------------------------------------
// The input channel carries one word of 80 bits: data[79:64] is the sign and
// biased exponent, data[63:0] the explicit mantissa. The output channel
// carries the 64-bit double pattern of the converted value.
// A word is taken in every cycle in which the pipeline advances. The pipeline
// has three register stages: normalization, alignment with round-bit
// extraction, and rounding with packing. The accepting edge loads the first
// stage; the word then passes the second and is offered from the third.
// Throughput is one word per cycle while the receiver takes results.
// When the receiver stalls, the whole pipeline holds: a stage advances only
// when the last stage is empty or being emptied, so nothing is lost or
// repeated. Input ready follows that same condition.
// Reset clears all valid bits; payload registers are not reset.
// Infinity and NaN inputs give signed infinity, zero mantissas signed zero,
// and rounding is a single ties-to-even step, also in the subnormal range.
// ----------------------------------------------------------------------------
`default_nettype none
module extended80_to_double (
	input  wire logic   clk,
	input  wire logic   arst_n,
	e2d_word_if.sink    in_word,
	e2d_word_if.source  out_word
);
	logic            en;
	logic            v_s1, v_s2, v_s3;
	e2d_pkg::norm_t  d_s1;
	e2d_pkg::align_t d_s2;
	logic [63:0]     d_s3;

	// The pipeline moves as one when the output register is free or leaving.
	assign en = !v_s3 || out_word.ready;
	assign in_word.ready  = en;
	assign out_word.valid = v_s3;
	assign out_word.data  = d_s3;

	e2d_norm u_norm (
		.clk, .arst_n, .en,
		.vin               (in_word.valid),
		.sign_and_exponent (in_word.data[79:64]),
		.mantissa          (in_word.data[63:0]),
		.v_s1, .d_s1
	);

	e2d_align u_align (.clk, .arst_n, .en, .v_s1, .d_s1, .v_s2, .d_s2);

	e2d_round u_round (.clk, .arst_n, .en, .v_s2, .d_s2, .v_s3, .d_s3);
endmodule
`default_nettype wire

// File: rtl/core/e2d_norm.sv
// ----------------------------------------------------------------------------
// e2d_norm: classification and normalization stage
// Counts leading zeros, shifts the mantissa up and forms the double exponent.
// ----------------------------------------------------------------------------
`default_nettype none
module e2d_norm (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            vin,
	input  wire logic [15:0]     sign_and_exponent,
	input  wire logic [63:0]     mantissa,
	output logic                 v_s1,
	output e2d_pkg::norm_t       d_s1
);
	logic [6:0]     lz;
	e2d_pkg::norm_t nx;

	always_comb begin
		lz = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (mantissa[i]) lz = 7'(63 - i);
		end
		nx.sign = sign_and_exponent[15];
		nx.mant = mantissa << lz[5:0];
		nx.be   = 18'({3'b0, sign_and_exponent[14:0]}) - 18'(e2d_pkg::EXT_BIAS)
			+ 18'(e2d_pkg::DBL_BIAS) - 18'(lz);
		if (sign_and_exponent[14:0] == e2d_pkg::EXT_EXP_MAX) begin
			nx.kind = e2d_pkg::KIND_INF;
		end else if (mantissa == 64'd0) begin
			nx.kind = e2d_pkg::KIND_ZERO;
		end else begin
			nx.kind = e2d_pkg::KIND_NUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) d_s1 <= nx;
	end
endmodule
`default_nettype wire

// File: rtl/core/e2d_align.sv
// ----------------------------------------------------------------------------
// e2d_align: range check and alignment stage
// Picks the shift for the normal or subnormal range and finds the round bit.
// ----------------------------------------------------------------------------
`default_nettype none
module e2d_align (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_s1,
	input  wire e2d_pkg::norm_t  d_s1,
	output logic                 v_s2,
	output e2d_pkg::align_t      d_s2
);
	e2d_pkg::align_t ax;
	logic signed [17:0] be;
	logic [6:0]  sh;
	logic [63:0] rem, half, mask;

	always_comb begin
		be = $signed(d_s1.be);
		ax.sign = d_s1.sign;
		ax.kind = d_s1.kind;
		ax.base = 64'd0;
		sh = 7'd11;
		if (d_s1.kind == e2d_pkg::KIND_NUM) begin
			if (be >= 18'sd2047) begin
				ax.kind = e2d_pkg::KIND_INF;
			end else if (be >= 18'sd1) begin
				ax.base = {1'b0, 11'(be - 18'sd1), 52'd0};
			end else if (be < -18'sd52) begin
				ax.kind = e2d_pkg::KIND_ZERO;
			end else begin
				sh = 7'(18'sd12 - be);
			end
		end
		if (sh < 7'd64) begin
			ax.q = d_s1.mant >> sh[5:0];
			mask = (64'd1 << sh[5:0]) - 64'd1;
			rem  = d_s1.mant & mask;
			half = 64'd1 << (sh[5:0] - 6'd1);
		end else begin
			mask = '1;
			ax.q = 64'd0;
			rem  = d_s1.mant;
			half = 64'h8000_0000_0000_0000;
		end
		ax.rnd_up = (rem > half) || (rem == half && ax.q[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) d_s2 <= ax;
	end
endmodule
`default_nettype wire

// File: rtl/core/e2d_round.sv
// ----------------------------------------------------------------------------
// e2d_round: rounding and packing stage
// Adds the round increment and assembles the final double pattern.
// ----------------------------------------------------------------------------
`default_nettype none
module e2d_round (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            v_s2,
	input  wire e2d_pkg::align_t d_s2,
	output logic                 v_s3,
	output logic [63:0]          d_s3
);
	logic [63:0] r;

	always_comb begin
		case (d_s2.kind)
			e2d_pkg::KIND_INF:  r = {d_s2.sign, e2d_pkg::DBL_EXP_INF, 52'd0};
			e2d_pkg::KIND_ZERO: r = {d_s2.sign, 63'd0};
			default:            r = {d_s2.sign, 63'd0}
				| (d_s2.base + d_s2.q + 64'(d_s2.rnd_up));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) d_s3 <= r;
	end
endmodule
`default_nettype wire
